@@ rtl/ptas_pkg.sv @@
// Shared types, constants and helper functions for the pinhole target angle solver.
package ptas_pkg;

  localparam int COORD_WIDTH       = 16;
  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int CORDIC_ITERATIONS = 16;

  localparam int REG_WIDTH  = 16;
  localparam int SUM_WIDTH  = COORD_WIDTH + 2;
  localparam int PROD_WIDTH = SUM_WIDTH + REG_WIDTH;
  localparam int DIVN_WIDTH = PROD_WIDTH + 8;
  localparam int NORM_BITS  = 30;
  localparam int SQ_WIDTH   = 2 * NORM_BITS + 2;
  localparam int ROOT_STEPS = SQ_WIDTH / 2;
  localparam int CORD_WIDTH = NORM_BITS + 4;
  localparam int ZACC_WIDTH = 33;
  localparam int ROUND_SH   = 30 - ANGLE_FRAC_BITS;
  localparam int YAW_WIDTH   = 16;
  localparam int PITCH_WIDTH = 15;
  localparam int CNT_WIDTH  = 6;
  localparam int IDX_WIDTH  = 3;

  localparam logic signed [ZACC_WIDTH-1:0] HALF_PI_Q30 = ZACC_WIDTH'(64'sd1686629713);

  localparam logic ACT_UPDATE  = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTRE_X  = 3'd2,
    REG_CENTRE_Y  = 3'd3,
    REG_DISTANCE  = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_NORM,
    ST_SQ,
    ST_ADD,
    ST_SQRT,
    ST_CSTART,
    ST_CORD,
    ST_DONE
  } state_t;

  // Q30 arctangent of 2^-i
  function automatic logic [30:0] atan_at(input logic [4:0] idx);
    logic [30:0] v;
    unique case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // clamp to +-pi/2, round half away from zero to the output fraction
  function automatic logic [YAW_WIDTH-1:0] angle_round(input logic signed [ZACC_WIDTH-1:0] z);
    logic signed [ZACC_WIDTH-1:0] zc;
    logic [ZACC_WIDTH-1:0] mag;
    logic [ZACC_WIDTH-1:0] r;
    zc = z;
    if (z > HALF_PI_Q30) zc = HALF_PI_Q30;
    if (z < -HALF_PI_Q30) zc = -HALF_PI_Q30;
    mag = zc[ZACC_WIDTH-1] ? ZACC_WIDTH'(-zc) : ZACC_WIDTH'(zc);
    r = (mag + (ZACC_WIDTH'(1) << (ROUND_SH - 1))) >> ROUND_SH;
    if (zc[ZACC_WIDTH-1]) r = -r;
    return r[YAW_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/ptas_if.sv @@
// Request and result channel interfaces of the angle solver.
interface ptas_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        is_armor;
  logic        four_corners;
  logic [15:0] corner0_x;
  logic [15:0] corner0_y;
  logic [15:0] corner1_x;
  logic [15:0] corner1_y;
  logic [15:0] corner2_x;
  logic [15:0] corner2_y;
  logic [15:0] corner3_x;
  logic [15:0] corner3_y;
  modport source (output valid, action, is_armor, four_corners, corner0_x, corner0_y,
                  corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
                  input ready);
  modport sink (input valid, action, is_armor, four_corners, corner0_x, corner0_y,
                corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
                output ready);
endinterface

interface ptas_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] pitch_angle;
  logic               roll_angle;
  logic               have_target;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, have_target,
                  input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, have_target,
                output ready);
endinterface

@@ rtl/pinhole_target_angle_solver.sv @@
// Top level: corner store, shared divider / root / CORDIC sequencer and result register.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | action, is_armor, four_corners, corner0..3 x/y
//  res     | out | valid/ready   | yaw_angle, pitch_angle, roll_angle, have_target
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// A request with a target runs two 42-step restoring divisions, up to 12
// normalize shifts, a 31-step integer root and two 16-step CORDIC runs on the
// one shared unit each. Requests before any target skip the arithmetic and
// give a result without a target. req.ready is high only in idle.
// rst is synchronous; it restores register defaults and clears the target.
// A result waiting on res.ready holds the sequencer in its last state.
module pinhole_target_angle_solver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ptas_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  logic [ptas_pkg::REG_WIDTH-1:0]   cfg_data,
  ptas_req_if.sink                         req,
  ptas_res_if.source                       res
);
  import ptas_pkg::*;

  state_t state, state_next;

  logic [REG_WIDTH-1:0] focal_x, focal_y, centre_x, centre_y, target_distance;
  logic [SUM_WIDTH-1:0] corner_sum_x, corner_sum_y;
  logic                 target_valid;

  logic                 pass;
  logic [CNT_WIDTH-1:0] cnt;
  logic [SUM_WIDTH-1:0] dmag;
  logic                 dneg;
  logic [DIVN_WIDTH-1:0] div_n;
  logic [SUM_WIDTH-1:0] div_d;
  logic [SUM_WIDTH-1:0] rem;
  logic [DIVN_WIDTH-1:0] mx, my;
  logic                 nx, ny;
  logic [REG_WIDTH+7:0] mz;
  logic [SQ_WIDTH-1:0]  sq, acc, root, bitv;
  logic signed [CORD_WIDTH-1:0] cx, cy;
  logic signed [ZACC_WIDTH-1:0] cz;
  logic                 zero_vec;
  logic [YAW_WIDTH-1:0]   yaw_r;
  logic [PITCH_WIDTH-1:0] pitch_r;
  logic                 have_r;
  logic                 res_valid;
  logic [YAW_WIDTH-1:0]   out_yaw;
  logic [PITCH_WIDTH-1:0] out_pitch;
  logic                 out_have;

  // combinational helpers
  logic [SUM_WIDTH-1:0] sel_sum, sel_c;
  logic [REG_WIDTH-1:0] sel_f;
  logic [SUM_WIDTH:0]   trial;
  logic                 ge;
  logic [SUM_WIDTH:0]   trial_sub;
  logic                 over;
  logic [SQ_WIDTH-1:0]  root_try;
  logic signed [CORD_WIDTH-1:0] sx, sy;
  logic signed [ZACC_WIDTH-1:0] cz_next;
  logic [YAW_WIDTH-1:0] ang;
  logic                 last_div, last_root, last_cord;

  assign req.ready = (state == ST_IDLE);
  assign res.valid = res_valid;
  assign res.yaw_angle = out_yaw;
  assign res.pitch_angle = out_pitch;
  assign res.roll_angle = 1'b0;
  assign res.have_target = out_have;

  assign sel_sum = pass ? corner_sum_y : corner_sum_x;
  assign sel_c   = pass ? {centre_y, 2'b00} : {centre_x, 2'b00};
  assign sel_f   = pass ? focal_y : focal_x;
  assign trial   = {rem, div_n[DIVN_WIDTH-1]};
  assign ge      = trial >= {1'b0, div_d};
  assign trial_sub = trial - {1'b0, div_d};
  assign over    = (|mx[DIVN_WIDTH-1:NORM_BITS]) || (|my[DIVN_WIDTH-1:NORM_BITS]);
  assign root_try = root + bitv;
  assign sx = cx >>> cnt;
  assign sy = cy >>> cnt;
  assign cz_next = (cy > 0) ? cz + ZACC_WIDTH'(atan_at(cnt[4:0]))
                            : cz - ZACC_WIDTH'(atan_at(cnt[4:0]));
  assign ang = zero_vec ? '0 : angle_round(cz_next);
  assign last_div  = (cnt == CNT_WIDTH'(DIVN_WIDTH - 1));
  assign last_root = (cnt == CNT_WIDTH'(ROOT_STEPS - 1));
  assign last_cord = (cnt == CNT_WIDTH'(CORDIC_ITERATIONS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && req.action == ACT_REQUEST)
          state_next = target_valid ? ST_DIFF : ST_DONE;
      end
      ST_DIFF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (last_div) state_next = pass ? ST_NORM : ST_DIFF;
      end
      ST_NORM: begin
        if (!over) state_next = ST_SQ;
      end
      ST_SQ: begin
        if (pass) state_next = ST_ADD;
      end
      ST_ADD:  state_next = ST_SQRT;
      ST_SQRT: begin
        if (last_root) state_next = ST_CSTART;
      end
      ST_CSTART: state_next = ST_CORD;
      ST_CORD: begin
        if (last_cord) state_next = pass ? ST_DONE : ST_CSTART;
      end
      ST_DONE: begin
        if (!res_valid || res.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration, target store and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 16'd9600;
      focal_y <= 16'd9600;
      centre_x <= 16'd5120;
      centre_y <= 16'd3840;
      target_distance <= 16'd3000;
      corner_sum_x <= '0;
      corner_sum_y <= '0;
      target_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FOCAL_X:  focal_x <= cfg_data;
          REG_FOCAL_Y:  focal_y <= cfg_data;
          REG_CENTRE_X: centre_x <= cfg_data;
          REG_CENTRE_Y: centre_y <= cfg_data;
          REG_DISTANCE: target_distance <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_IDLE && req.valid && req.action == ACT_UPDATE
          && req.is_armor && req.four_corners) begin
        corner_sum_x <= SUM_WIDTH'(req.corner0_x) + SUM_WIDTH'(req.corner1_x)
                      + SUM_WIDTH'(req.corner2_x) + SUM_WIDTH'(req.corner3_x);
        corner_sum_y <= SUM_WIDTH'(req.corner0_y) + SUM_WIDTH'(req.corner1_y)
                      + SUM_WIDTH'(req.corner2_y) + SUM_WIDTH'(req.corner3_y);
        target_valid <= 1'b1;
      end
      if (state == ST_DONE && (!res_valid || res.ready)) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res_valid || res.ready)) begin
      out_yaw <= yaw_r;
      out_pitch <= pitch_r;
      out_have <= have_r;
    end
  end

  // shared arithmetic sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pass <= 1'b0;
        have_r <= target_valid;
        yaw_r <= '0;
        pitch_r <= '0;
        mz <= {target_distance, 8'd0};
      end
      ST_DIFF: begin
        dneg <= sel_sum < sel_c;
        dmag <= (sel_sum < sel_c) ? sel_c - sel_sum : sel_sum - sel_c;
      end
      ST_MUL: begin
        div_n <= {PROD_WIDTH'(dmag) * PROD_WIDTH'(target_distance), 8'd0};
        div_d <= {((sel_f == '0) ? REG_WIDTH'(1) : sel_f), 2'b00};
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= ge ? trial_sub[SUM_WIDTH-1:0] : trial[SUM_WIDTH-1:0];
        div_n <= {div_n[DIVN_WIDTH-2:0], ge};
        cnt <= cnt + 1'b1;
        if (last_div) begin
          if (pass) begin
            my <= {div_n[DIVN_WIDTH-2:0], ge};
            ny <= dneg;
          end else begin
            mx <= {div_n[DIVN_WIDTH-2:0], ge};
            nx <= dneg;
          end
          pass <= ~pass;
        end
      end
      ST_NORM: begin
        if (over) begin
          mx <= mx >> 1;
          my <= my >> 1;
          mz <= mz >> 1;
        end
      end
      ST_SQ: begin
        if (!pass) begin
          sq <= SQ_WIDTH'(mx[NORM_BITS-1:0] * mx[NORM_BITS-1:0]);
        end else begin
          acc <= sq;
          sq <= SQ_WIDTH'(mz * mz);
        end
        pass <= 1'b1;
      end
      ST_ADD: begin
        acc <= acc + sq;
        root <= '0;
        bitv <= SQ_WIDTH'(1) << (SQ_WIDTH - 2);
        cnt <= '0;
        pass <= 1'b0;
      end
      ST_SQRT: begin
        if (acc >= root_try) begin
          acc <= acc - root_try;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt <= cnt + 1'b1;
      end
      ST_CSTART: begin
        if (!pass) begin
          cx <= CORD_WIDTH'(mz);
          cy <= nx ? -CORD_WIDTH'(mx[NORM_BITS-1:0]) : CORD_WIDTH'(mx[NORM_BITS-1:0]);
          zero_vec <= (mz == '0) && (mx[NORM_BITS-1:0] == '0);
        end else begin
          cx <= CORD_WIDTH'(root[NORM_BITS:0]);
          cy <= ny ? -CORD_WIDTH'(my[NORM_BITS-1:0]) : CORD_WIDTH'(my[NORM_BITS-1:0]);
          zero_vec <= (root[NORM_BITS:0] == '0) && (my[NORM_BITS-1:0] == '0);
        end
        cz <= '0;
        cnt <= '0;
      end
      ST_CORD: begin
        if (cy > 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
        end
        cz <= cz_next;
        cnt <= cnt + 1'b1;
        if (last_cord) begin
          if (pass) pitch_r <= ang[PITCH_WIDTH-1:0];
          else yaw_r <= ang;
          pass <= 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside done state");
  a_no_target_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.have_target) |-> (res.yaw_angle == 0 && res.pitch_angle == 0))
    else $error("nonzero angle without target");
  a_cord_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORD) |-> (cnt < CNT_WIDTH'(CORDIC_ITERATIONS)))
    else $error("cordic step count overrun");
`endif

endmodule
